[sv/v3alu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3alu_pkg
// Beat types, command codes and saturation helpers for the vector3 alu.
// ----------------------------------------------------------------------------
package v3alu_pkg;

    localparam logic [3:0] CMD_ADD    = 4'd0;
    localparam logic [3:0] CMD_SUB    = 4'd1;
    localparam logic [3:0] CMD_MUL    = 4'd2;
    localparam logic [3:0] CMD_DIV    = 4'd3;
    localparam logic [3:0] CMD_DOT    = 4'd4;
    localparam logic [3:0] CMD_CROSS  = 4'd5;
    localparam logic [3:0] CMD_LENGTH = 4'd6;
    localparam logic [3:0] CMD_NORM   = 4'd7;
    localparam logic [3:0] CMD_LERP   = 4'd8;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    localparam logic signed [65:0] W_MAX  = 66'sd2147483647;
    localparam logic signed [65:0] W_MIN  = -66'sd2147483648;
    localparam logic signed [65:0] W_HALF = 66'sd32768;
    localparam logic signed [32:0] Q_ONE  = 33'sd65536;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] lerp_factor;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic               divide_by_zero;
        logic               overflowed;
    } out_beat_t;

    // side payload that rides along the sqrt and divide pipes
    typedef struct packed {
        logic [3:0]       cmd;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [2:0][31:0] r;
        logic             dz;
        logic             ov;
    } item_t;

    typedef struct packed {
        logic        ov;
        logic [31:0] val;
    } sat_t;

    function automatic sat_t sat66(input logic signed [65:0] v);
        sat_t s;
        if (v > W_MAX)
        begin
            s.ov  = 1'b1;
            s.val = S32_MAX;
        end
        else if (v < W_MIN)
        begin
            s.ov  = 1'b1;
            s.val = S32_MIN;
        end
        else
        begin
            s.ov  = 1'b0;
            s.val = v[31:0];
        end
        return s;
    endfunction

    // Q32.32 to Q16.16, round half up
    function automatic logic signed [65:0] rnd16(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + W_HALF;
        return t >>> 16;
    endfunction

endpackage
`default_nettype wire

[sv/v3alu_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3alu_sqrt
// Pipelined rounded integer square root of a 64-bit radicand, one result
// bit per stage, with a side payload carried alongside.
// ----------------------------------------------------------------------------
module v3alu_sqrt
    import v3alu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [63:0] in_rad,
    input  wire item_t       in_tag,
    output logic             out_valid,
    output logic [32:0]      out_root,
    output item_t            out_tag
);

    localparam int STEPS = 32;

    logic [STEPS:0] vld_reg;
    logic [63:0]    rad_reg  [STEPS+1];
    logic [33:0]    rem_reg  [STEPS+1];
    logic [31:0]    root_reg [STEPS+1];
    item_t          tag_reg  [STEPS+1];

    logic [35:0]    cur      [1:STEPS];
    logic [35:0]    trial    [1:STEPS];
    logic           ge       [1:STEPS];
    logic [33:0]    rem_next [1:STEPS];
    logic [31:0]    root_next[1:STEPS];

    logic           out_valid_reg;
    logic [32:0]    out_root_reg;
    logic [32:0]    out_root_next;
    item_t          out_tag_reg;

    always_comb
    begin
        for (int k = 1; k <= STEPS; k++)
        begin
            cur[k]       = {rem_reg[k-1], rad_reg[k-1][63:62]};
            trial[k]     = {2'b00, root_reg[k-1], 2'b01};
            ge[k]        = (cur[k] >= trial[k]);
            rem_next[k]  = ge[k] ? 34'(cur[k] - trial[k]) : cur[k][33:0];
            root_next[k] = {root_reg[k-1][30:0], ge[k]};
        end
    end

    // remainder above the floor root means the root rounds up
    always_comb
    begin
        if (rem_reg[STEPS] > {2'b00, root_reg[STEPS]})
            out_root_next = {1'b0, root_reg[STEPS]} + 33'd1;
        else
            out_root_next = {1'b0, root_reg[STEPS]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[STEPS-1:0], in_valid};
            out_valid_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= in_rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            tag_reg[0]  <= in_tag;
            for (int k = 1; k <= STEPS; k++)
            begin
                rad_reg[k]  <= {rad_reg[k-1][61:0], 2'b00};
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                tag_reg[k]  <= tag_reg[k-1];
            end
            out_root_reg <= out_root_next;
            out_tag_reg  <= tag_reg[STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_root  = out_root_reg;
    assign out_tag   = out_tag_reg;

endmodule
`default_nettype wire

[sv/v3alu_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// v3alu_div
// Three-lane pipelined Q16.16 divider: (num << 16) / den truncated toward
// zero, saturated, with zero-divisor handling. One quotient bit per stage.
// ----------------------------------------------------------------------------
module v3alu_div
    import v3alu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [2:0][31:0]  num,
    input  wire logic [2:0][33:0]  den,
    input  wire item_t             in_tag,
    output logic                   out_valid,
    output logic [2:0][31:0]       quo,
    output logic [2:0]             quo_ov,
    output logic [2:0]             quo_dz,
    output item_t                  out_tag
);

    localparam int STEPS = 32;
    localparam int LANES = 3;

    logic [STEPS:0] vld_reg;
    item_t          tag_reg  [STEPS+1];
    logic [32:0]    rem_reg  [STEPS+1][LANES];
    logic [31:0]    low_reg  [STEPS+1][LANES];
    logic [31:0]    q_reg    [STEPS+1][LANES];
    logic [32:0]    dmag_reg [STEPS+1][LANES];
    logic           neg_reg  [STEPS+1][LANES];
    logic           nsgn_reg [STEPS+1][LANES];
    logic           big_reg  [STEPS+1][LANES];
    logic           dz_reg   [STEPS+1][LANES];

    logic [31:0]    nmag     [LANES];
    logic [32:0]    dmag     [LANES];
    logic [33:0]    cur      [1:STEPS][LANES];
    logic           ge       [1:STEPS][LANES];
    logic [32:0]    rem_next [1:STEPS][LANES];

    logic              out_valid_reg;
    logic [2:0][31:0]  quo_reg,  quo_next;
    logic [2:0]        ov_reg,   ov_next;
    logic [2:0]        dz_reg_o, dz_next;
    item_t             out_tag_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            nmag[l] = num[l][31] ? (~num[l] + 32'd1) : num[l];
            dmag[l] = den[l][33] ? 33'(~den[l] + 34'd1) : den[l][32:0];
        end
    end

    always_comb
    begin
        for (int k = 1; k <= STEPS; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                cur[k][l]      = {rem_reg[k-1][l], low_reg[k-1][l][31]};
                ge[k][l]       = (cur[k][l] >= {1'b0, dmag_reg[k-1][l]});
                rem_next[k][l] = ge[k][l] ? 33'(cur[k][l] - {1'b0, dmag_reg[k-1][l]})
                                          : cur[k][l][32:0];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            ov_next[l]  = 1'b0;
            dz_next[l]  = 1'b0;
            quo_next[l] = q_reg[STEPS][l];
            if (dz_reg[STEPS][l])
            begin
                dz_next[l]  = 1'b1;
                quo_next[l] = nsgn_reg[STEPS][l] ? S32_MIN : S32_MAX;
            end
            else if (big_reg[STEPS][l])
            begin
                // quotient at least 2^32
                ov_next[l]  = 1'b1;
                quo_next[l] = neg_reg[STEPS][l] ? S32_MIN : S32_MAX;
            end
            else if (neg_reg[STEPS][l])
            begin
                if (q_reg[STEPS][l] > S32_MIN)
                begin
                    ov_next[l]  = 1'b1;
                    quo_next[l] = S32_MIN;
                end
                else
                    quo_next[l] = ~q_reg[STEPS][l] + 32'd1;
            end
            else if (q_reg[STEPS][l] > S32_MAX)
            begin
                ov_next[l]  = 1'b1;
                quo_next[l] = S32_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[STEPS-1:0], in_valid};
            out_valid_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l]  <= {17'd0, nmag[l][31:16]};
                low_reg[0][l]  <= {nmag[l][15:0], 16'd0};
                q_reg[0][l]    <= '0;
                dmag_reg[0][l] <= dmag[l];
                neg_reg[0][l]  <= num[l][31] ^ den[l][33];
                nsgn_reg[0][l] <= num[l][31];
                big_reg[0][l]  <= ({17'd0, nmag[l][31:16]} >= dmag[l]);
                dz_reg[0][l]   <= (den[l] == 34'd0);
            end
            for (int k = 1; k <= STEPS; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l]  <= rem_next[k][l];
                    low_reg[k][l]  <= {low_reg[k-1][l][30:0], 1'b0};
                    q_reg[k][l]    <= {q_reg[k-1][l][30:0], ge[k][l]};
                    dmag_reg[k][l] <= dmag_reg[k-1][l];
                    neg_reg[k][l]  <= neg_reg[k-1][l];
                    nsgn_reg[k][l] <= nsgn_reg[k-1][l];
                    big_reg[k][l]  <= big_reg[k-1][l];
                    dz_reg[k][l]   <= dz_reg[k-1][l];
                end
            end
            quo_reg     <= quo_next;
            ov_reg      <= ov_next;
            dz_reg_o    <= dz_next;
            out_tag_reg <= tag_reg[STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign quo       = quo_reg;
    assign quo_ov    = ov_reg;
    assign quo_dz    = dz_reg_o;
    assign out_tag   = out_tag_reg;

endmodule
`default_nettype wire

[sv/vector3_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_alu
// Three-component Q16.16 vector unit: add, sub, mul, div, dot, cross,
// length, normalize and lerp, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
//  channel  | signals                          | beat
//  ---------+----------------------------------+-------------------------
//  item     | item_valid, item_stall, item     | command, a, b, lerp weight
//  result   | result_valid, result_stall, res. | r_x/y/z and two flags
//
//  one beat enters per cycle while item_stall is low; each beat passes through
//  4 multiply/sum stages, 34 sqrt stages, 34 divide stages and the output register,
//  most of them in the bit-per-stage square root and divider
//  reset clears only the valid bits of every stage
//  result_stall with a waiting result freezes the whole pipe and stalls item
// ----------------------------------------------------------------------------
module vector3_alu
    import v3alu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire in_beat_t  item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_beat_t      result
);

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    logic en;

    logic signed [31:0] av [3];
    logic signed [31:0] bv [3];
    logic signed [32:0] kq, wq;
    logic signed [32:0] m1a_next [3], m1b_next [3], m2a_next [3], m2b_next [3];
    logic signed [32:0] as_next  [3];
    item_t              item_next;

    logic               s1_valid_reg;
    item_t              s1_item_reg;
    logic signed [32:0] s1_m1a_reg [3], s1_m1b_reg [3], s1_m2a_reg [3], s1_m2b_reg [3];
    logic signed [32:0] s1_as_reg  [3];

    logic               s2_valid_reg;
    item_t              s2_item_reg;
    logic signed [65:0] s2_p1_reg [3], s2_p2_reg [3];
    logic signed [32:0] s2_as_reg [3];

    logic               s3_valid_reg;
    item_t              s3_item_reg;
    logic signed [65:0] s3_lane_reg [3];
    logic signed [32:0] s3_as_reg   [3];

    logic               s4_valid_reg;
    item_t              s4_item_reg;
    logic signed [65:0] s4_lane_reg [3];
    logic signed [65:0] s4_total_reg;
    logic signed [32:0] s4_as_reg   [3];

    item_t              sq_tag_next;
    sat_t               lane_sat [3];
    sat_t               tot_sat;

    logic               sq_valid;
    logic [32:0]        sq_root;
    item_t              sq_tag;

    item_t              dv_tag_next;
    logic [2:0][31:0]   dv_num;
    logic [2:0][33:0]   dv_den;

    logic               dv_valid;
    logic [2:0][31:0]   dv_q;
    logic [2:0]         dv_ov;
    logic [2:0]         dv_dz;
    item_t              dv_tag;

    logic               result_valid_reg;
    out_beat_t          result_reg, result_next;

    function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [65:0] sx66(input logic signed [32:0] v);
        return {{33{v[32]}}, v};
    endfunction

    assign en         = !(result_valid_reg && result_stall);
    assign item_stall = !en;

    // operand select
    always_comb
    begin
        av[0] = item.a_x;
        av[1] = item.a_y;
        av[2] = item.a_z;
        bv[0] = item.b_x;
        bv[1] = item.b_y;
        bv[2] = item.b_z;
        kq    = sx33(item.lerp_factor);
        wq    = Q_ONE - kq;
        for (int i = 0; i < 3; i++)
        begin
            m1a_next[i] = '0;
            m1b_next[i] = '0;
            m2a_next[i] = '0;
            m2b_next[i] = '0;
            as_next[i]  = (item.command == CMD_SUB) ? sx33(av[i]) - sx33(bv[i])
                                                    : sx33(av[i]) + sx33(bv[i]);
            case (item.command)
                CMD_MUL, CMD_DOT:
                begin
                    m1a_next[i] = sx33(av[i]);
                    m1b_next[i] = sx33(bv[i]);
                end
                CMD_CROSS:
                begin
                    m1a_next[i] = sx33(av[NXT[i]]);
                    m1b_next[i] = sx33(bv[PRV[i]]);
                    m2a_next[i] = -sx33(av[PRV[i]]);
                    m2b_next[i] = sx33(bv[NXT[i]]);
                end
                CMD_LERP:
                begin
                    m1a_next[i] = sx33(av[i]);
                    m1b_next[i] = wq;
                    m2a_next[i] = sx33(bv[i]);
                    m2b_next[i] = kq;
                end
                CMD_LENGTH, CMD_NORM:
                begin
                    m1a_next[i] = sx33(av[i]);
                    m1b_next[i] = sx33(av[i]);
                end
                default:
                begin
                end
            endcase
        end
        item_next.cmd = item.command;
        item_next.a   = {item.a_z, item.a_y, item.a_x};
        item_next.b   = {item.b_z, item.b_y, item.b_x};
        item_next.r   = '0;
        item_next.dz  = 1'b0;
        item_next.ov  = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= item_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg  <= item_next;
            s2_item_reg  <= s1_item_reg;
            s3_item_reg  <= s2_item_reg;
            s4_item_reg  <= s3_item_reg;
            s4_total_reg <= s3_lane_reg[0] + s3_lane_reg[1] + s3_lane_reg[2];
            for (int i = 0; i < 3; i++)
            begin
                s1_m1a_reg[i]  <= m1a_next[i];
                s1_m1b_reg[i]  <= m1b_next[i];
                s1_m2a_reg[i]  <= m2a_next[i];
                s1_m2b_reg[i]  <= m2b_next[i];
                s1_as_reg[i]   <= as_next[i];
                s2_p1_reg[i]   <= s1_m1a_reg[i] * s1_m1b_reg[i];
                s2_p2_reg[i]   <= s1_m2a_reg[i] * s1_m2b_reg[i];
                s2_as_reg[i]   <= s1_as_reg[i];
                s3_lane_reg[i] <= s2_p1_reg[i] + s2_p2_reg[i];
                s3_as_reg[i]   <= s2_as_reg[i];
                s4_lane_reg[i] <= s3_lane_reg[i];
                s4_as_reg[i]   <= s3_as_reg[i];
            end
        end
    end

    // round products and saturate everything that needs no sqrt or divide
    always_comb
    begin
        sq_tag_next    = s4_item_reg;
        sq_tag_next.r  = '0;
        sq_tag_next.dz = 1'b0;
        sq_tag_next.ov = 1'b0;
        tot_sat        = sat66(rnd16(s4_total_reg));
        for (int i = 0; i < 3; i++)
        begin
            if (s4_item_reg.cmd == CMD_ADD || s4_item_reg.cmd == CMD_SUB)
                lane_sat[i] = sat66(sx66(s4_as_reg[i]));
            else
                lane_sat[i] = sat66(rnd16(s4_lane_reg[i]));
        end
        case (s4_item_reg.cmd)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_CROSS, CMD_LERP:
            begin
                for (int i = 0; i < 3; i++)
                    sq_tag_next.r[i] = lane_sat[i].val;
                sq_tag_next.ov = lane_sat[0].ov | lane_sat[1].ov | lane_sat[2].ov;
            end
            CMD_DOT:
            begin
                sq_tag_next.r[0] = tot_sat.val;
                sq_tag_next.ov   = tot_sat.ov;
            end
            default:
            begin
            end
        endcase
    end

    v3alu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .in_rad    (s4_total_reg[63:0]),
        .in_tag    (sq_tag_next),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    always_comb
    begin
        dv_tag_next = sq_tag;
        if (sq_tag.cmd == CMD_LENGTH)
        begin
            if (sq_root > {1'b0, S32_MAX})
            begin
                dv_tag_next.r[0] = S32_MAX;
                dv_tag_next.ov   = 1'b1;
            end
            else
                dv_tag_next.r[0] = sq_root[31:0];
        end
        for (int i = 0; i < 3; i++)
        begin
            dv_num[i] = sq_tag.a[i];
            if (sq_tag.cmd == CMD_NORM)
                dv_den[i] = {1'b0, sq_root};
            else
                dv_den[i] = {{2{sq_tag.b[i][31]}}, sq_tag.b[i]};
        end
    end

    v3alu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .num       (dv_num),
        .den       (dv_den),
        .in_tag    (dv_tag_next),
        .out_valid (dv_valid),
        .quo       (dv_q),
        .quo_ov    (dv_ov),
        .quo_dz    (dv_dz),
        .out_tag   (dv_tag)
    );

    always_comb
    begin
        if (dv_tag.cmd inside {CMD_DIV, CMD_NORM})
        begin
            result_next.r_x            = dv_q[0];
            result_next.r_y            = dv_q[1];
            result_next.r_z            = dv_q[2];
            result_next.divide_by_zero = |dv_dz;
            result_next.overflowed     = |dv_ov;
        end
        else
        begin
            result_next.r_x            = dv_tag.r[0];
            result_next.r_y            = dv_tag.r[1];
            result_next.r_z            = dv_tag.r[2];
            result_next.divide_by_zero = dv_tag.dz;
            result_next.overflowed     = dv_tag.ov;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (en)
            result_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // an accepted beat lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> s1_valid_reg)
        else $error("accepted beat missing from first stage");

    // a held result freezes the inner stages
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(s4_valid_reg) && $stable(sq_valid)
            && $stable(dv_valid))
        else $error("pipe moved while output held");

    // normalize divides all lanes by one length: zero for all or for none
    a_norm_dz: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid && dv_tag.cmd == CMD_NORM |->
            ($countones(dv_dz) == 0 || $countones(dv_dz) == 3))
        else $error("normalize zero-length flag differs between lanes");

endmodule
`default_nettype wire

[verif/tb_vector3_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector3_alu
// Drives command beats into the vector unit under several idle and stall
// mixes, predicts every result in Q16.16 and compares each field in order.
// ----------------------------------------------------------------------------
module tb_vector3_alu;
    import v3alu_pkg::*;

    localparam int LATENCY   = 73;
    localparam int MAX_CYCLE = 400000;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_beat_t  item;
    logic      result_valid;
    logic      result_stall;
    out_beat_t result;

    vector3_alu dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    in_beat_t  pending_items[$];
    out_beat_t expected_results[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_off;
    bit        hold_phase;
    bit        hold_armed;
    int        cycle_count = 0;
    int        error_count = 0;

    // ---------------- predictor ----------------
    function automatic logic signed [63:0] clamp_s32(input logic signed [63:0] v,
                                                      inout bit ov);
        if (v > 64'sd2147483647)
        begin
            ov = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            ov = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // exact sum or difference of up to two products, rounded once, half up
    function automatic logic signed [63:0] round_products(
        input logic signed [63:0] p0, input logic signed [63:0] q0,
        input logic signed [63:0] p1, input logic signed [63:0] q1,
        input bit negate, inout bit ov);
        logic signed [127:0] s;
        logic signed [127:0] t;
        s = 128'(p0) * 128'(q0);
        t = 128'(p1) * 128'(q1);
        s = negate ? s - t : s + t;
        s = (s + 128'sd32768) >>> 16;
        if (s > 128'sd2147483647)
        begin
            ov = 1;
            return 64'sd2147483647;
        end
        if (s < -128'sd2147483648)
        begin
            ov = 1;
            return -64'sd2147483648;
        end
        return 64'(s);
    endfunction

    function automatic logic signed [63:0] q16_divide(input logic signed [63:0] num,
                                                       input logic signed [63:0] den,
                                                       inout bit dz, inout bit ov);
        if (den == 0)
        begin
            dz = 1;
            return (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
        end
        return clamp_s32((num * 64'sd65536) / den, ov);
    endfunction

    function automatic logic [63:0] rounded_sqrt(input logic [63:0] s);
        logic [63:0] op;
        logic [63:0] res;
        logic [63:0] bitv;
        op   = s;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > op)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (op >= res + bitv)
            begin
                op  = op - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        if (op > res)
            res++;
        return res;
    endfunction

    function automatic out_beat_t predict_vector_op(input in_beat_t it);
        logic signed [63:0] a[3];
        logic signed [63:0] b[3];
        logic signed [63:0] r[3];
        logic signed [63:0] k;
        logic signed [63:0] w;
        logic signed [63:0] len;
        logic [63:0]        sq;
        bit dz;
        bit ov;
        out_beat_t o;
        a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
        b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z;
        k = it.lerp_factor;
        w = 64'sd65536 - k;
        r[0] = 0; r[1] = 0; r[2] = 0;
        dz = 0;
        ov = 0;
        case (it.command)
            CMD_ADD:
                for (int i = 0; i < 3; i++)
                    r[i] = clamp_s32(a[i] + b[i], ov);
            CMD_SUB:
                for (int i = 0; i < 3; i++)
                    r[i] = clamp_s32(a[i] - b[i], ov);
            CMD_MUL:
                for (int i = 0; i < 3; i++)
                    r[i] = round_products(a[i], b[i], 0, 0, 0, ov);
            CMD_DIV:
                for (int i = 0; i < 3; i++)
                    r[i] = q16_divide(a[i], b[i], dz, ov);
            CMD_DOT:
            begin
                logic signed [127:0] s;
                s = 128'(a[0]) * 128'(b[0]) + 128'(a[1]) * 128'(b[1])
                  + 128'(a[2]) * 128'(b[2]);
                s = (s + 128'sd32768) >>> 16;
                if (s > 128'sd2147483647)
                begin
                    ov = 1;
                    r[0] = 64'sd2147483647;
                end
                else if (s < -128'sd2147483648)
                begin
                    ov = 1;
                    r[0] = -64'sd2147483648;
                end
                else
                    r[0] = 64'(s);
            end
            CMD_CROSS:
                for (int i = 0; i < 3; i++)
                    r[i] = round_products(a[(i+1)%3], b[(i+2)%3],
                                          a[(i+2)%3], b[(i+1)%3], 1, ov);
            CMD_LENGTH, CMD_NORM:
            begin
                sq = 64'(a[0] * a[0]) + 64'(a[1] * a[1]) + 64'(a[2] * a[2]);
                len = $signed(rounded_sqrt(sq));
                if (it.command == CMD_LENGTH)
                    r[0] = clamp_s32(len, ov);
                else
                    for (int i = 0; i < 3; i++)
                        r[i] = q16_divide(a[i], len, dz, ov);
            end
            CMD_LERP:
                for (int i = 0; i < 3; i++)
                    r[i] = round_products(a[i], w, b[i], k, 0, ov);
            default: ;
        endcase
        o.r_x = r[0][31:0];
        o.r_y = r[1][31:0];
        o.r_z = r[2][31:0];
        o.divide_by_zero = dz;
        o.overflowed = ov;
        return o;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0: return S32_MAX;
            1: return S32_MIN;
            2: return 32'd0;
            3: return 32'(int'($urandom_range(0, 8)) - 4) << 16;
            4, 5: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            6: return $urandom_range(0, 3) - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(input logic [3:0] cmd,
                              input logic [31:0] ax, input logic [31:0] ay,
                              input logic [31:0] az, input logic [31:0] bx,
                              input logic [31:0] by, input logic [31:0] bz,
                              input logic [31:0] kf);
        in_beat_t it;
        it.command = cmd;
        it.a_x = ax; it.a_y = ay; it.a_z = az;
        it.b_x = bx; it.b_y = by; it.b_z = bz;
        it.lerp_factor = kf;
        pending_items.push_back(it);
    endtask

    task automatic queue_random(input int n);
        logic [3:0] cmd;
        for (int i = 0; i < n; i++)
        begin
            cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
            queue_item(cmd, rand_q16(), rand_q16(),
                       ($urandom_range(0, 3) == 0) ? 32'd0 : rand_q16(),
                       rand_q16(), rand_q16(),
                       ($urandom_range(0, 3) == 0) ? 32'd0 : rand_q16(),
                       rand_q16());
        end
    endtask

    // checked mid-cycle so a beat still on the input counts as pending
    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || expected_results.size() != 0 || item_valid)
            @(negedge clk);
    endtask

    // ---------------- clock, reset, watchdog ----------------
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- receiver hold-off counter ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off   <= 0;
            hold_armed <= 1'b0;
        end
        else if (hold_phase && !hold_armed)
        begin
            hold_off   <= 300;
            hold_armed <= 1'b1;
        end
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (!item_valid || !item_stall)
            begin
                if (item_valid)
                    expected_results.push_back(predict_vector_op(item));
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item_valid <= 1'b1;
                    item       <= pending_items.pop_front();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t exp_beat;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    error_count++;
                end
                else
                begin
                    exp_beat = expected_results.pop_front();
                    if (result.r_x !== exp_beat.r_x)
                    begin
                        $error("r_x expected %h actual %h", exp_beat.r_x, result.r_x);
                        error_count++;
                    end
                    if (result.r_y !== exp_beat.r_y)
                    begin
                        $error("r_y expected %h actual %h", exp_beat.r_y, result.r_y);
                        error_count++;
                    end
                    if (result.r_z !== exp_beat.r_z)
                    begin
                        $error("r_z expected %h actual %h", exp_beat.r_z, result.r_z);
                        error_count++;
                    end
                    if (result.divide_by_zero !== exp_beat.divide_by_zero)
                    begin
                        $error("divide_by_zero expected %b actual %b",
                               exp_beat.divide_by_zero, result.divide_by_zero);
                        error_count++;
                    end
                    if (result.overflowed !== exp_beat.overflowed)
                    begin
                        $error("overflowed expected %b actual %b",
                               exp_beat.overflowed, result.overflowed);
                        error_count++;
                    end
                end
            end
            if (hold_off > 0)
                result_stall <= 1'b1;
            else
                result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ---------------- test sequence ----------------
    initial
    begin
        int waited;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_phase     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every command, extremes, zero divisors, zero vectors
        queue_item(CMD_ADD, S32_MAX, S32_MIN, 32'd1, 32'd1, S32_MIN, 32'd2, 0);
        queue_item(CMD_SUB, S32_MIN, S32_MAX, 32'd5, 32'd1, S32_MIN, 32'd3, 0);
        queue_item(CMD_MUL, S32_MAX, S32_MIN, 32'h0001_8000, S32_MAX, S32_MIN,
                   32'hFFFF_8000, 0);
        queue_item(CMD_MUL, 32'h0000_8000, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1,
                   32'h0000_8000, 0);
        queue_item(CMD_DIV, 32'h0003_0000, 32'hFFFD_0000, 32'd0, 32'd0, 32'd0, 32'd0, 0);
        queue_item(CMD_DIV, S32_MAX, S32_MIN, 32'h0001_0000, 32'd1, 32'd1,
                   32'h0002_0000, 0);
        queue_item(CMD_DOT, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'h0003_0000,
                   32'h0004_0000, 32'd0, 0);
        queue_item(CMD_DOT, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, 0);
        queue_item(CMD_CROSS, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 0);
        queue_item(CMD_CROSS, S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, 0);
        queue_item(CMD_LENGTH, 32'h0003_0000, 32'h0004_0000, 32'd0, 0, 0, 0, 0);
        queue_item(CMD_LENGTH, 32'd0, 32'd0, 32'd0, 0, 0, 0, 0);
        queue_item(CMD_LENGTH, S32_MIN, S32_MIN, S32_MIN, 0, 0, 0, 0);
        queue_item(CMD_NORM, 32'h0003_0000, 32'hFFFC_0000, 32'd0, 0, 0, 0, 0);
        queue_item(CMD_NORM, 32'd0, 32'd0, 32'd0, 0, 0, 0, 0);
        queue_item(CMD_NORM, S32_MIN, S32_MAX, 32'd1, 0, 0, 0, 0);
        queue_item(CMD_LERP, 32'h0001_0000, 32'd0, S32_MAX, 32'h0003_0000, S32_MIN,
                   32'd0, 32'h0000_8000);
        queue_item(CMD_LERP, S32_MAX, S32_MIN, 32'd7, S32_MIN, S32_MAX, 32'd9, S32_MIN);
        queue_item(CMD_LERP, S32_MAX, S32_MIN, 32'd1, S32_MIN, S32_MAX, 32'd3, S32_MAX);
        queue_item(4'd9, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
        queue_item(4'd15, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        wait_drained();

        // random phases with different idle and stall mixes
        queue_random(300);
        wait_drained();
        send_idle_pct = 47;
        queue_random(300);
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 47;
        queue_random(300);
        wait_drained();
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        queue_random(250);
        wait_drained();

        // long receiver hold-off so the pipe fills and backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_phase     = 1'b1;
        queue_random(200);
        wait_drained();

        waited = 0;
        while (waited < 2 * LATENCY)
        begin
            @(posedge clk);
            waited++;
        end
        if (error_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
